>>> design/psnr_pkg.sv
// Shared constants and types for the PSNR image metric.
// Used by the front, queue, back and top-level files; depends on nothing.
package psnr_pkg;

    // Fraction bits of the base-2 logarithm.
    localparam int LOG_FRAC = 30;
    // Mantissa width of the logarithm unit, Q1.31.
    localparam int MANT_W = 32;
    // 255 squared.
    localparam logic [15:0] PEAK_SQUARED = 16'd65025;
    // 10*log10(2) in Q.24.
    localparam int KCONST_W = 26;
    localparam int K_FRAC = 24;
    localparam logic [KCONST_W-1:0] TEN_LOG10_2_Q24 = 26'd50504453;
    // Low slice of the log difference for the split multiply.
    localparam int DLO_W = 18;

    // Status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // One finished result.
    typedef struct packed {
        logic        empty_image;
        logic        psnr_infinite;
        logic [15:0] psnr_db_q8;
    } psnr_result_t;

endpackage

>>> design/psnr_front.sv
// Front end: accepts pixel-pair requests, accumulates squared error and count.
// Pushes the totals of an image into the queue on the last pair. Uses psnr_pkg.
module psnr_front #(
    parameter int MAX_PIXELS_LOG2 = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,
    input  logic                          s_tlast,
    input  psnr_pkg::fifo_status_t        fifo_stat,
    output logic                          push,
    output logic [2*MAX_PIXELS_LOG2+16:0] push_data
);
    import psnr_pkg::*;

    localparam int SW = 16 + MAX_PIXELS_LOG2;
    localparam int CW = MAX_PIXELS_LOG2 + 1;

    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    pix_a, pix_b, diff;
    logic [15:0]   sq;
    logic          accept;
    logic          room;

    // A request is taken whenever the queue can hold a finished image.
    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Squared difference of the current pair.
    assign pix_a = s_tdata[7:0];
    assign pix_b = s_tdata[15:8];
    assign diff  = (pix_a >= pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
    assign sq    = {8'b0, diff} * {8'b0, diff};

    // Pairs past the pixel limit are dropped; the count tops out at a power of two.
    assign room = !cnt_reg[CW-1];

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (room)
        begin
            sum_next = sum_reg + SW'(sq);
            cnt_next = cnt_reg + CW'(1);
        end
    end

    // The last pair is included in the totals handed to the back end.
    assign push      = accept && s_tlast;
    assign push_data = {cnt_next, sum_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

>>> design/psnr_fifo.sv
// Two-entry queue that carries per-image totals from the front to the back end.
// Uses psnr_pkg for the status struct.
module psnr_fifo #(
    parameter int WIDTH = 65
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output psnr_pkg::fifo_status_t stat
);
    import psnr_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

>>> design/psnr_back.sv
// Back end: turns per-image totals into PSNR through a shared base-2 log unit.
// Owns the output register. Uses psnr_pkg.
module psnr_back #(
    parameter int MAX_PIXELS_LOG2    = 24,
    parameter int PSNR_FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psnr_pkg::fifo_status_t        fifo_stat,
    input  logic [2*MAX_PIXELS_LOG2+16:0] pop_data,
    output logic                          pop,
    input  logic [15:0]                   threshold,
    output logic                          out_valid,
    input  logic                          out_ready,
    output psnr_pkg::psnr_result_t        out_res
);
    import psnr_pkg::*;

    localparam int SW   = 16 + MAX_PIXELS_LOG2;
    localparam int CW   = MAX_PIXELS_LOG2 + 1;
    localparam int NW   = CW + 16;
    localparam int XW   = (NW > MANT_W) ? NW : MANT_W;
    localparam int EW   = $clog2(XW);
    localparam int LGW  = EW + LOG_FRAC;
    localparam int DHI_W = LGW - DLO_W;
    localparam int PW   = LGW + KCONST_W;
    localparam int SH   = LOG_FRAC + K_FRAC - PSNR_FRACTION_BITS;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (SH - 1);
    localparam logic [PW:0] SAT  = (PW+1)'(16'hFFFF);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_CMP   = 4'd2;
    localparam logic [3:0] ST_NORM  = 4'd3;
    localparam logic [3:0] ST_SQR   = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_MULLO = 4'd6;
    localparam logic [3:0] ST_MULHI = 4'd7;
    localparam logic [3:0] ST_ROUND = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]      state_reg, state_next;
    logic [SW-1:0]   sum_reg;
    logic [CW-1:0]   cnt_reg;
    logic [NW-1:0]   thr_prod_reg;
    logic [NW-1:0]   num_reg;
    logic [XW-1:0]   x_reg;
    logic [EW-1:0]   e_reg;
    logic [MANT_W-1:0] m_reg;
    logic [LOG_FRAC-1:0] frac_reg;
    logic [4:0]      iter_reg;
    logic            second_reg;
    logic [LGW-1:0]  lg_num_reg;
    logic [LGW-1:0]  lg_s_reg;
    logic [LGW-1:0]  d_reg;
    logic [PW-1:0]   p_reg;
    psnr_result_t    res_reg;
    logic            out_valid_reg;
    psnr_result_t    out_res_reg;

    logic [NW-1:0]        thr_prod;
    logic [NW-1:0]        num;
    logic                 is_inf;
    logic [2*MANT_W-1:0]  sq64;
    logic [MANT_W:0]      sq_t;
    logic                 frac_bit;
    logic [MANT_W-1:0]    m_sq;
    logic [LOG_FRAC-1:0]  frac_sq;
    logic [LGW-1:0]       lg_done;
    logic                 iter_last;
    logic [DLO_W+KCONST_W-1:0] p_lo;
    logic [DHI_W+KCONST_W-1:0] p_hi;
    logic [PW:0]          p_round;
    logic [PW:0]          p_q;
    logic                 out_load;

    // Threshold product and scaled peak for the current image.
    assign thr_prod = NW'(threshold) * NW'(cnt_reg);
    assign num      = NW'(PEAK_SQUARED) * NW'(cnt_reg);

    // Exact infinite test: sum * 2^16 <= threshold * count.
    assign is_inf = {sum_reg, 16'b0} <= (SW+16)'(thr_prod_reg);

    // One fraction bit of the logarithm per mantissa squaring.
    assign sq64     = {{MANT_W{1'b0}}, m_reg} * {{MANT_W{1'b0}}, m_reg};
    assign sq_t     = sq64[2*MANT_W-1:MANT_W-1];
    assign frac_bit = sq_t[MANT_W];
    assign m_sq     = frac_bit ? sq_t[MANT_W:1] : sq_t[MANT_W-1:0];
    assign frac_sq  = {frac_reg[LOG_FRAC-2:0], frac_bit};
    assign lg_done  = {e_reg, frac_sq};
    assign iter_last = (iter_reg == 5'(LOG_FRAC - 1));

    // Log difference times 10*log10(2), split in two partial products.
    assign p_lo = (DLO_W+KCONST_W)'(d_reg[DLO_W-1:0]) * (DLO_W+KCONST_W)'(TEN_LOG10_2_Q24);
    assign p_hi = (DHI_W+KCONST_W)'(d_reg[LGW-1:DLO_W]) * (DHI_W+KCONST_W)'(TEN_LOG10_2_Q24);

    // Round half up to the output fraction bits.
    assign p_round = {1'b0, p_reg} + HALF;
    assign p_q     = p_round >> SH;

    assign pop      = (state_reg == ST_IDLE) && !fifo_stat.empty;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!fifo_stat.empty) state_next = ST_MUL;
            ST_MUL:   state_next = ST_CMP;
            ST_CMP:
            begin
                if ((cnt_reg == '0) || is_inf)
                    state_next = ST_DONE;
                else
                    state_next = ST_NORM;
            end
            ST_NORM:  if (x_reg[XW-1]) state_next = ST_SQR;
            ST_SQR:
            begin
                if (iter_last)
                    state_next = second_reg ? ST_DIFF : ST_NORM;
            end
            ST_DIFF:  state_next = ST_MULLO;
            ST_MULLO: state_next = ST_MULHI;
            ST_MULHI: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            second_reg    <= 1'b0;
            iter_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CMP)
            begin
                second_reg <= 1'b0;
            end
            else if ((state_reg == ST_SQR) && iter_last)
            begin
                second_reg <= 1'b1;
            end
            if (state_reg == ST_NORM)
            begin
                iter_reg <= 5'd0;
            end
            else if (state_reg == ST_SQR)
            begin
                iter_reg <= iter_reg + 5'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sum_reg <= pop_data[SW-1:0];
                cnt_reg <= pop_data[SW+CW-1:SW];
            end
            ST_MUL:
            begin
                thr_prod_reg <= thr_prod;
                num_reg      <= num;
            end
            ST_CMP:
            begin
                if (cnt_reg == '0)
                begin
                    res_reg <= '{empty_image: 1'b1, psnr_infinite: 1'b0, psnr_db_q8: 16'h0000};
                end
                else
                begin
                    res_reg <= '{empty_image: 1'b0, psnr_infinite: 1'b1, psnr_db_q8: 16'hFFFF};
                end
                x_reg <= XW'(num_reg);
                e_reg <= EW'(XW - 1);
            end
            ST_NORM:
            begin
                // Shift until the leading one reaches the top.
                if (x_reg[XW-1])
                begin
                    m_reg    <= x_reg[XW-1 -: MANT_W];
                    frac_reg <= '0;
                end
                else
                begin
                    x_reg <= {x_reg[XW-2:0], 1'b0};
                    e_reg <= e_reg - EW'(1);
                end
            end
            ST_SQR:
            begin
                m_reg    <= m_sq;
                frac_reg <= frac_sq;
                if (iter_last)
                begin
                    if (second_reg)
                    begin
                        lg_s_reg <= lg_done;
                    end
                    else
                    begin
                        lg_num_reg <= lg_done;
                        x_reg      <= XW'(sum_reg);
                        e_reg      <= EW'(XW - 1);
                    end
                end
            end
            ST_DIFF:
            begin
                d_reg <= (lg_num_reg > lg_s_reg) ? (lg_num_reg - lg_s_reg) : '0;
            end
            ST_MULLO:
            begin
                p_reg <= PW'(p_lo);
            end
            ST_MULHI:
            begin
                p_reg <= p_reg + (PW'(p_hi) << DLO_W);
            end
            ST_ROUND:
            begin
                res_reg.empty_image   <= 1'b0;
                res_reg.psnr_infinite <= 1'b0;
                res_reg.psnr_db_q8    <= (p_q > SAT) ? 16'hFFFF : p_q[15:0];
            end
            default:
            begin
                if (out_load)
                begin
                    out_res_reg <= res_reg;
                end
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> design/psnr_8bit_image_metric.sv
// Top level of the PSNR image metric: config register, front, queue and back end.
// Depends on psnr_pkg, psnr_front, psnr_fifo and psnr_back.
//
//  Channel   Direction  Payload                                   Handshake
//  s_*       in         tdata: pixel_first, pixel_second; tlast    tvalid/tready
//  m_*       out        tdata: psnr_db_q8; tuser: infinite, empty  tvalid/tready
//  cfg_*     in         zero_mse_threshold                        cfg_we, no wait
//
// Pixel pairs are taken one per cycle while the two-entry totals queue has room.
// Each image result runs the two log operands through the 41-bit log2 unit,
// with one normalizing shift per leading zero and 30 mantissa squarings per
// logarithm (one normalizing shift or one mantissa squaring per cycle); an
// infinite result skips the log unit. Reset clears the accumulators, the queue and
// the output valid; the threshold resets to zero. A stalled output holds its
// result while the front keeps going until the queue is full.
module psnr_8bit_image_metric #(
    parameter int MAX_PIXELS_LOG2    = 24,
    parameter int PSNR_FRACTION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] pixel_first, [15:8] pixel_second
    input  logic        s_tlast,   // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] psnr_db_q8
    output logic [1:0]  m_tuser,   // [0] psnr_infinite, [1] empty_image
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata  // zero_mse_threshold
);
    import psnr_pkg::*;

    localparam int QW = 2 * MAX_PIXELS_LOG2 + 17;

    logic [15:0]   thr_reg;
    logic          push;
    logic          pop;
    logic [QW-1:0] push_data;
    logic [QW-1:0] pop_data;
    fifo_status_t  fifo_stat;
    psnr_result_t  out_res;

    // Infinite-PSNR threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    psnr_front #(
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    psnr_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    psnr_back #(
        .MAX_PIXELS_LOG2    (MAX_PIXELS_LOG2),
        .PSNR_FRACTION_BITS (PSNR_FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .threshold (thr_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Result fields onto the output stream.
    assign m_tdata = out_res.psnr_db_q8;
    assign m_tuser = {out_res.empty_image, out_res.psnr_infinite};

endmodule

>>> design/psnr_checker.sv
// Port-level checks of the PSNR image metric output stream, bound to the top level.
// Depends only on the top-level ports.
module psnr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output result changed while stalled");

    // An infinite result reports the top code.
    a_inf_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'hFFFF)
        else $error("infinite flag without saturated value");

    // An empty image reports zero and is never infinite.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 16'h0000 && !m_tuser[0])
        else $error("empty image with nonzero result");

endmodule

bind psnr_8bit_image_metric psnr_checker u_psnr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb_top.sv
// Self-checking testbench for the PSNR image metric: streams pixel pairs, predicts each image
// result in fixed point and compares it with the output stream, with random gaps and stalls.
// Depends on psnr_pkg and psnr_8bit_image_metric.
module tb_top;
    import psnr_pkg::*;

    localparam int MAX_PIXELS_LOG2    = 24;
    localparam int PSNR_FRACTION_BITS = 8;
    localparam int CLK_PERIOD         = 20;
    localparam int RESET_CYCLES       = 9;
    localparam int SETTLE_CYCLES      = 200;
    localparam int RANDOM_ITEMS       = 520;
    localparam int LIMIT_CYCLES       = 1000000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] pixel_first, [15:8] pixel_second
    logic        s_tlast   = 1'b0; // last_pixel
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [15:0] psnr_db_q8
    logic [1:0]  m_tuser;          // [0] psnr_infinite, [1] empty_image
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Prediction state.
    logic [63:0] sq_err_sum;
    logic [63:0] pix_count;
    logic [15:0] model_threshold;
    psnr_result_t pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned items_sent     = 0;

    psnr_8bit_image_metric #(
        .MAX_PIXELS_LOG2   (MAX_PIXELS_LOG2),
        .PSNR_FRACTION_BITS(PSNR_FRACTION_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Clock.
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Base-2 logarithm with LOG_FRAC fraction bits, by repeated mantissa squaring.
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int unsigned e;
        logic [63:0] mant;
        logic [63:0] acc;
        int i;
        e = 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        if (e > 31)
            mant = x >> (e - 31);
        else
            mant = x << (31 - e);
        acc = 64'(e) << LOG_FRAC;
        for (i = LOG_FRAC - 1; i >= 0; i--)
        begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000)
            begin
                acc[i] = 1'b1;
                mant   = mant >> 1;
            end
        end
        return acc;
    endfunction

    // Result of one finished image from its error sum and pixel count.
    function automatic psnr_result_t predict_psnr(input logic [63:0] sum,
                                                  input logic [63:0] count,
                                                  input logic [15:0] thr);
        psnr_result_t res;
        logic [63:0] lg_num;
        logic [63:0] lg_sum;
        logic [63:0] diff;
        logic [63:0] prod;
        int unsigned sh;
        res = '0;
        sh  = LOG_FRAC + K_FRAC - PSNR_FRACTION_BITS;
        if (count == 0)
        begin
            res.empty_image = 1'b1;
        end
        else if ((sum << 16) <= 64'(thr) * count)
        begin
            res.psnr_infinite = 1'b1;
            res.psnr_db_q8    = 16'hFFFF;
        end
        else
        begin
            lg_num = log2_fixed(64'(PEAK_SQUARED) * count);
            lg_sum = log2_fixed(sum);
            diff   = (lg_num > lg_sum) ? lg_num - lg_sum : 64'd0;
            prod   = diff * 64'(TEN_LOG10_2_Q24);
            prod   = (prod + (64'd1 << (sh - 1))) >> sh;
            res.psnr_db_q8 = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
        end
        return res;
    endfunction

    // Receiver: ready pattern changes mode when the phase counter wraps.
    int unsigned rx_phase = 0;
    int unsigned rx_mode  = 0;
    always @(posedge clk)
    begin
        if (rx_phase == 0)
            rx_mode <= $urandom_range(0, 3);
        rx_phase <= (rx_phase == 49) ? 0 : rx_phase + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_phase % 8 == 0);
            default: m_tready <= (rx_phase >= 44);
        endcase
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        psnr_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: psnr_db_q8=%0d tuser=%b", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.psnr_db_q8)
                begin
                    $error("psnr_db_q8: expected %0d, actual %0d", exp_res.psnr_db_q8, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== exp_res.psnr_infinite)
                begin
                    $error("psnr_infinite: expected %0d, actual %0d",
                           exp_res.psnr_infinite, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== exp_res.empty_image)
                begin
                    $error("empty_image: expected %0d, actual %0d",
                           exp_res.empty_image, m_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one pixel pair; the sender runs in random bursts with random gaps.
    task automatic send_pair(input logic [7:0] first, input logic [7:0] second,
                             input logic last);
        int unsigned gap;
        logic [63:0] d;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {second, first};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
        // Request accepted: update the predicted accumulators.
        if (pix_count < (64'd1 << MAX_PIXELS_LOG2))
        begin
            d = (first >= second) ? 64'(first - second) : 64'(second - first);
            sq_err_sum = sq_err_sum + d * d;
            pix_count  = pix_count + 1;
        end
        if (last)
        begin
            pending_results.push_back(predict_psnr(sq_err_sum, pix_count, model_threshold));
            sq_err_sum = 0;
            pix_count  = 0;
        end
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic wait_results_done();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the infinite-PSNR threshold while the block is idle.
    task automatic write_threshold(input logic [15:0] value);
        wait_results_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_threshold = value;
    endtask

    // One image of the given size; the content style sets how close the two images are.
    task automatic send_image(input int unsigned size, input int unsigned style);
        logic [7:0] a;
        logic [7:0] b;
        int k;
        int unsigned i;
        for (i = 0; i < size; i++)
        begin
            a = 8'($urandom_range(0, 255));
            case (style)
                0: b = 8'($urandom_range(0, 255));
                1:
                begin
                    k = int'(a) + int'($urandom_range(0, 4)) - 2;
                    b = (k < 0) ? 8'd0 : (k > 255) ? 8'd255 : k[7:0];
                end
                2: b = a;
                default:
                begin
                    a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
            endcase
            send_pair(a, b, i == size - 1);
        end
    endtask

    // Pick a random image size, mostly small.
    function automatic int unsigned random_image_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 150);
    endfunction

    // Single-pixel and short images at the extremes of the pixel range.
    task automatic test_pixel_extremes();
        write_threshold(16'd0);
        send_pair(8'd0, 8'd0, 1'b1);
        send_pair(8'd255, 8'd255, 1'b1);
        send_pair(8'd0, 8'd255, 1'b1);
        send_pair(8'd255, 8'd0, 1'b1);
        send_pair(8'd1, 8'd0, 1'b1);
        send_pair(8'd170, 8'd85, 1'b1);
        send_pair(8'd85, 8'd170, 1'b1);
        send_pair(8'd0, 8'd255, 1'b0);
        send_pair(8'd255, 8'd0, 1'b0);
        send_pair(8'd12, 8'd13, 1'b1);
        wait_results_done();
    endtask

    // Mean squared error right at and around the infinite threshold.
    task automatic test_threshold_boundary();
        write_threshold(16'hFFFF);
        // MSE of one is just above the largest threshold.
        send_pair(8'd1, 8'd0, 1'b1);
        // MSE of one half is below it.
        send_pair(8'd1, 8'd0, 1'b0);
        send_pair(8'd7, 8'd7, 1'b1);
        // MSE exactly equal to the threshold counts as infinite.
        write_threshold(16'h8000);
        send_pair(8'd0, 8'd1, 1'b0);
        send_pair(8'd0, 8'd0, 1'b1);
        write_threshold(16'h7FFF);
        send_pair(8'd0, 8'd1, 1'b0);
        send_pair(8'd0, 8'd0, 1'b1);
        wait_results_done();
    endtask

    // A few near-equal images under a range of threshold settings.
    task automatic test_threshold_sweep();
        logic [15:0] settings[6];
        int s;
        int n;
        settings = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'hFFFE, 16'($urandom)};
        for (s = 0; s < 6; s++)
        begin
            write_threshold(settings[s]);
            for (n = 0; n < 3; n++)
                send_image($urandom_range(1, 12), 1);
        end
        wait_results_done();
    endtask

    // Random images of random content; the threshold changes between phases.
    task automatic test_random_images();
        int unsigned start;
        int unsigned next_phase;
        int unsigned r;
        start      = items_sent;
        next_phase = start + 120;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent >= next_phase)
            begin
                r = $urandom_range(0, 3);
                write_threshold(r == 0 ? 16'd0 : r == 1 ? 16'hFFFF : 16'($urandom));
                next_phase = items_sent + 120;
            end
            send_image(random_image_size(), $urandom_range(0, 3));
        end
        wait_results_done();
    endtask

    // Main sequence.
    initial
    begin
        sq_err_sum      = 0;
        pix_count       = 0;
        model_threshold = 16'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixel_extremes();
        test_threshold_boundary();
        test_threshold_sweep();
        test_random_images();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
